// ===== sv/mbts_pkg.sv =====
// Shared types, constants and helpers for the memory bus test sequencer.
`default_nettype none
package mbts_pkg;

	localparam int DATA_BITS   = 8;
	localparam int ADDR_BITS   = 16;
	localparam int SEG_W       = 16;
	localparam int OFF_W       = 16;
	localparam int LINES_W     = 5;
	localparam int LINE_IDX_W  = 4;
	localparam int AMASK_W     = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int LINE_CAP    = (ADDR_BITS < 16) ? ADDR_BITS : 16;

	// input op codes
	localparam logic OP_START     = 1'b0;
	localparam logic OP_READ_DATA = 1'b1;

	// result kind codes
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_BASE_SEGMENT  = 2'd0;
	localparam logic [1:0] CFG_BASE_OFFSET   = 2'd1;
	localparam logic [1:0] CFG_ADDRESS_LINES = 2'd2;

	localparam logic [OFF_W-1:0]     RST_BASE_OFFSET = 16'h2800;
	localparam logic [LINES_W-1:0]   RST_ADDR_LINES  = 5'd11;
	localparam logic [DATA_BITS-1:0] ADDR_PATTERN    = 8'hAA;

	// work descriptors passed from front to back
	typedef enum logic [1:0] {
		DESC_WRRD,    // write pattern at base, then read it back
		DESC_ASTART,  // clear power-of-two locations, write 0xAA at base, read line 0
		DESC_AREAD,   // read one power-of-two location
		DESC_DONE     // report both masks
	} desc_kind_t;

	typedef struct packed {
		desc_kind_t             kind;
		logic [DATA_BITS-1:0]   pattern;
		logic [LINE_IDX_W-1:0]  line;
		logic [DATA_BITS-1:0]   data_mask;
		logic [AMASK_W-1:0]     addr_mask;
	} desc_t;

	typedef struct packed {
		logic [SEG_W-1:0]   segment;
		logic [OFF_W-1:0]   offset;
		logic [LINES_W-1:0] lines;
	} cfg_t;

	function automatic logic [LINES_W-1:0] line_count(input logic [LINES_W-1:0] raw);
		logic [LINES_W-1:0] cap;
		cap = LINES_W'(LINE_CAP);
		return (raw > cap) ? cap : raw;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mbts_front.sv =====
// Front end: accepts input beats, tracks test progress, queues work descriptors.
`default_nettype none
module mbts_front import mbts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [DATA_BITS-1:0]  read_data,
	input  wire logic [LINES_W-1:0]    lines,
	input  wire logic                  q_full,
	output logic                       push,
	output desc_t                      push_desc
);

	typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_ADDR} phase_t;

	phase_t                  phase_q, phase_d;
	logic [DATA_BITS-1:0]    pattern_q, pattern_d;
	logic [LINES_W-1:0]      line_q, line_d;
	logic [DATA_BITS-1:0]    dfault_q, dfault_d;
	logic [AMASK_W-1:0]      afault_q, afault_d;

	logic                    accept;
	logic [DATA_BITS-1:0]    pat_shift;
	logic [DATA_BITS-1:0]    dmask;
	logic [AMASK_W-1:0]      amask;
	logic [LINES_W-1:0]      line_inc;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign pat_shift = {pattern_q[DATA_BITS-2:0], 1'b0};
	assign dmask     = dfault_q | ((read_data != pattern_q) ? pattern_q : '0);
	assign amask     = afault_q |
		((read_data != '0) ? (AMASK_W'(1) << line_q[LINE_IDX_W-1:0]) : '0);
	assign line_inc  = line_q + LINES_W'(1);

	always_comb begin
		phase_d   = phase_q;
		pattern_d = pattern_q;
		line_d    = line_q;
		dfault_d  = dfault_q;
		afault_d  = afault_q;
		push      = 1'b0;
		push_desc = '0;
		if (accept) begin
			if (op == OP_START) begin
				phase_d           = PH_DATA;
				pattern_d         = DATA_BITS'(1);
				line_d            = '0;
				dfault_d          = '0;
				afault_d          = '0;
				push              = 1'b1;
				push_desc.kind    = DESC_WRRD;
				push_desc.pattern = DATA_BITS'(1);
			end else begin
				case (phase_q)
					PH_DATA: begin
						dfault_d  = dmask;
						pattern_d = pat_shift;
						push      = 1'b1;
						if (pat_shift != '0) begin
							push_desc.kind    = DESC_WRRD;
							push_desc.pattern = pat_shift;
						end else if (lines == '0) begin
							phase_d             = PH_IDLE;
							push_desc.kind      = DESC_DONE;
							push_desc.data_mask = dmask;
							push_desc.addr_mask = afault_q;
						end else begin
							phase_d        = PH_ADDR;
							line_d         = '0;
							push_desc.kind = DESC_ASTART;
						end
					end
					PH_ADDR: begin
						afault_d = amask;
						line_d   = line_inc;
						push     = 1'b1;
						if (line_inc < lines) begin
							push_desc.kind = DESC_AREAD;
							push_desc.line = line_inc[LINE_IDX_W-1:0];
						end else begin
							phase_d             = PH_IDLE;
							push_desc.kind      = DESC_DONE;
							push_desc.data_mask = dfault_q;
							push_desc.addr_mask = amask;
						end
					end
					default: begin
						// read data while idle is dropped
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pattern_q <= '0;
			line_q    <= '0;
			dfault_q  <= '0;
			afault_q  <= '0;
		end else begin
			phase_q   <= phase_d;
			pattern_q <= pattern_d;
			line_q    <= line_d;
			dfault_q  <= dfault_d;
			afault_q  <= afault_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/mbts_queue.sv =====
// Short descriptor queue between front and back.
`default_nettype none
module mbts_queue import mbts_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire desc_t  push_desc,
	output logic        full,
	input  wire logic   pop,
	output logic        pop_valid,
	output desc_t       pop_desc
);

	desc_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_desc  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/mbts_back.sv =====
// Back end: expands descriptors into memory command and done beats.
`default_nettype none
module mbts_back import mbts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  q_valid,
	input  wire desc_t                 q_desc,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 kind,
	output logic [SEG_W-1:0]           mem_segment,
	output logic [OFF_W-1:0]           mem_offset,
	output logic [DATA_BITS-1:0]       write_data,
	output logic [DATA_BITS-1:0]       data_fault_mask,
	output logic [AMASK_W-1:0]         addr_fault_mask,
	output logic                       last
);

	desc_t                  cur_q;
	logic                   cur_valid_q;
	logic [LINES_W-1:0]     step_q;
	logic                   out_valid_q;

	logic                   issue;
	logic [1:0]             b_kind;
	logic [OFF_W-1:0]       b_loc;
	logic [DATA_BITS-1:0]   b_wd;
	logic                   b_last;
	logic                   b_done;

	assign issue = cur_valid_q && (!out_valid_q || out_ready);
	assign q_pop = q_valid && (!cur_valid_q || (issue && b_last));

	always_comb begin
		b_kind = KIND_READ;
		b_loc  = '0;
		b_wd   = '0;
		b_last = 1'b0;
		b_done = 1'b0;
		case (cur_q.kind)
			DESC_WRRD: begin
				if (step_q == '0) begin
					b_kind = KIND_WRITE;
					b_wd   = cur_q.pattern;
				end else begin
					b_last = 1'b1;
				end
			end
			DESC_ASTART: begin
				if (step_q < cfg.lines) begin
					b_kind = KIND_WRITE;
					b_loc  = OFF_W'(1) << step_q[LINE_IDX_W-1:0];
				end else if (step_q == cfg.lines) begin
					b_kind = KIND_WRITE;
					b_wd   = ADDR_PATTERN;
				end else begin
					b_loc  = OFF_W'(1);
					b_last = 1'b1;
				end
			end
			DESC_AREAD: begin
				b_loc  = OFF_W'(1) << cur_q.line;
				b_last = 1'b1;
			end
			DESC_DONE: begin
				b_kind = KIND_DONE;
				b_done = 1'b1;
				b_last = 1'b1;
			end
			default: begin
				b_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (issue && b_last) begin
				cur_valid_q <= 1'b0;
			end else if (issue) begin
				step_q <= step_q + LINES_W'(1);
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (issue) begin
			kind            <= b_kind;
			mem_segment     <= b_done ? '0 : cfg.segment;
			mem_offset      <= b_done ? '0 : cfg.offset + b_loc;
			write_data      <= b_wd;
			data_fault_mask <= b_done ? cur_q.data_mask : '0;
			addr_fault_mask <= b_done ? cur_q.addr_mask : '0;
			last            <= b_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/memory_bus_test_sequencer_unit.sv =====
// Memory bus test sequencer top level: walking-ones data test, then address line test.
// Path of an item: descriptor queue, back-end descriptor register, output registers.
// Throughput: one input beat per cycle while the two-entry descriptor queue has room;
// output issues one result beat per cycle while out_ready is high; a data-to-address
// item yields (address lines + 2) beats, a read while idle none, others one or two.
// Reset (arst_n low, asynchronous): test idle, masks clear, queue and output empty.
`default_nettype none
module memory_bus_test_sequencer_unit import mbts_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [15:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [DATA_BITS-1:0]  read_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 kind,
	output logic [SEG_W-1:0]           mem_segment,
	output logic [OFF_W-1:0]           mem_offset,
	output logic [DATA_BITS-1:0]       write_data,
	output logic [DATA_BITS-1:0]       data_fault_mask,
	output logic [AMASK_W-1:0]         addr_fault_mask,
	output logic                       last
);

	logic [SEG_W-1:0]    seg_q;
	logic [OFF_W-1:0]    off_q;
	logic [LINES_W-1:0]  lines_raw_q;
	cfg_t                cfg;
	logic                q_full;
	logic                push;
	desc_t               push_desc;
	logic                q_pop;
	logic                q_valid;
	desc_t               q_desc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= '0;
			off_q       <= RST_BASE_OFFSET;
			lines_raw_q <= RST_ADDR_LINES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE_SEGMENT:  seg_q       <= cfg_data[SEG_W-1:0];
				CFG_BASE_OFFSET:   off_q       <= cfg_data[OFF_W-1:0];
				CFG_ADDRESS_LINES: lines_raw_q <= cfg_data[LINES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.segment = seg_q;
	assign cfg.offset  = off_q;
	assign cfg.lines   = line_count(lines_raw_q);

	mbts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.read_data (read_data),
		.lines     (cfg.lines),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	mbts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_desc  (q_desc)
	);

	mbts_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_valid         (q_valid),
		.q_desc          (q_desc),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.mem_segment     (mem_segment),
		.mem_offset      (mem_offset),
		.write_data      (write_data),
		.data_fault_mask (data_fault_mask),
		.addr_fault_mask (addr_fault_mask),
		.last            (last)
	);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |-> last)
		else $error("done beat without last");

	a_done_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |->
			mem_segment == '0 && mem_offset == '0 && write_data == '0)
		else $error("done beat carries command fields");

	a_cmd_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DONE |->
			data_fault_mask == '0 && addr_fault_mask == '0)
		else $error("command beat carries fault masks");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("descriptor pushed into full queue");

endmodule
`default_nettype wire

// ===== sim/memory_bus_test_sequencer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the memory bus test sequencer, scoreboard and handshake drivers.
module memory_bus_test_sequencer_unit_tb;
	import mbts_pkg::*;

	localparam int TOTAL_ITEMS   = 260;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_ADDR} test_phase_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [SEG_W-1:0]     segment;
		logic [OFF_W-1:0]     offset;
		logic [DATA_BITS-1:0] wdata;
		logic [DATA_BITS-1:0] dmask;
		logic [AMASK_W-1:0]   amask;
		logic                 last;
	} bus_beat_t;

	// Tracks the test sequence and holds the command/done beats still owed by the block.
	class bus_test_tracker;
		logic [SEG_W-1:0]     segment;
		logic [OFF_W-1:0]     base;
		logic [LINES_W-1:0]   lines_raw;
		test_phase_t          phase;
		logic [DATA_BITS-1:0] pattern;
		logic [LINES_W-1:0]   line_idx;
		logic [DATA_BITS-1:0] data_faults;
		logic [AMASK_W-1:0]   addr_faults;
		bus_beat_t            expected_cmds[$];
		int                   mismatches;
		int                   checked;
		int                   tests_done;
		int                   faulty_tests;

		function new();
			segment = '0;
			base = RST_BASE_OFFSET;
			lines_raw = RST_ADDR_LINES;
			phase = PH_IDLE;
			pattern = '0;
			line_idx = '0;
			data_faults = '0;
			addr_faults = '0;
			mismatches = 0;
			checked = 0;
			tests_done = 0;
			faulty_tests = 0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [15:0] value);
			case (idx)
				CFG_BASE_SEGMENT:  segment = value;
				CFG_BASE_OFFSET:   base = value;
				CFG_ADDRESS_LINES: lines_raw = value[LINES_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned lines_tested();
			return (lines_raw > LINE_CAP) ? LINE_CAP : lines_raw;
		endfunction

		function void push_cmd(input logic [1:0] k, input logic [15:0] loc,
				input logic [7:0] wd);
			bus_beat_t r;
			r = '0;
			r.kind = k;
			r.segment = segment;
			r.offset = base + loc;
			r.wdata = wd;
			expected_cmds.push_back(r);
		endfunction

		function void push_done();
			bus_beat_t r;
			r = '0;
			r.kind = KIND_DONE;
			r.dmask = data_faults;
			r.amask = addr_faults;
			expected_cmds.push_back(r);
			phase = PH_IDLE;
			tests_done++;
			if (data_faults != 0 || addr_faults != 0)
				faulty_tests++;
		endfunction

		// Returns the number of beats the item causes.
		function int note_input(input logic op_in, input logic [7:0] rd);
			int start_size;
			int unsigned lines;
			int n;
			start_size = expected_cmds.size();
			lines = lines_tested();
			if (op_in == OP_START) begin
				data_faults = '0;
				addr_faults = '0;
				pattern = 8'd1;
				line_idx = '0;
				phase = PH_DATA;
				push_cmd(KIND_WRITE, 16'd0, pattern);
				push_cmd(KIND_READ, 16'd0, 8'd0);
			end else if (phase == PH_DATA) begin
				if (rd != pattern)
					data_faults |= pattern;
				pattern = pattern << 1;
				if (pattern != 0) begin
					push_cmd(KIND_WRITE, 16'd0, pattern);
					push_cmd(KIND_READ, 16'd0, 8'd0);
				end else if (lines == 0) begin
					push_done();
				end else begin
					// clear every line location, then mark base
					for (int i = 0; i < lines; i++)
						push_cmd(KIND_WRITE, 16'd1 << i, 8'd0);
					push_cmd(KIND_WRITE, 16'd0, ADDR_PATTERN);
					line_idx = '0;
					phase = PH_ADDR;
					push_cmd(KIND_READ, 16'd1, 8'd0);
				end
			end else if (phase == PH_ADDR) begin
				if (rd != 0)
					addr_faults |= AMASK_W'(1) << line_idx[3:0];
				line_idx = line_idx + 1'b1;
				// line count is live: a shrink below the current line ends the test
				if (line_idx < lines)
					push_cmd(KIND_READ, 16'd1 << line_idx[3:0], 8'd0);
				else
					push_done();
			end
			n = expected_cmds.size() - start_size;
			if (n > 0)
				expected_cmds[expected_cmds.size() - 1].last = 1'b1;
			return n;
		endfunction

		function void report_field(input string name, input logic [15:0] want_v,
				input logic [15:0] got_v);
			if (want_v !== got_v) begin
				mismatches++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want_v, got_v);
			end
		endfunction

		function void check_result(input bus_beat_t got);
			bus_beat_t want;
			checked++;
			if (expected_cmds.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, actual kind %0d offset 0x%0h",
					$time, got.kind, got.offset);
				return;
			end
			want = expected_cmds.pop_front();
			report_field("kind", want.kind, got.kind);
			report_field("mem_segment", want.segment, got.segment);
			report_field("mem_offset", want.offset, got.offset);
			report_field("write_data", want.wdata, got.wdata);
			report_field("data_fault_mask", want.dmask, got.dmask);
			report_field("addr_fault_mask", want.amask, got.amask);
			report_field("last", want.last, got.last);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = CFG_BASE_SEGMENT;
	logic [15:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = OP_START;
	logic [DATA_BITS-1:0] read_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           kind;
	logic [SEG_W-1:0]     mem_segment;
	logic [OFF_W-1:0]     mem_offset;
	logic [DATA_BITS-1:0] write_data;
	logic [DATA_BITS-1:0] data_fault_mask;
	logic [AMASK_W-1:0]   addr_fault_mask;
	logic                 last;

	bus_test_tracker tracker = new();

	int  sent_items = 0;
	int  useful_items = 0;
	int  cfg_writes = 0;
	int  burst_left = 0;
	int  mid_test_changes = 0;
	int  restarts = 0;
	bit  draining = 1'b0;

	memory_bus_test_sequencer_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sender pacing: bursts of beats, mostly separated by idle gaps.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_item(input logic op_in, input logic [7:0] rd);
		pace();
		in_valid <= 1'b1;
		op <= op_in;
		read_data <= rd;
		do @(posedge clk); while (!in_ready);
		sent_items++;
		if (tracker.note_input(op_in, rd) > 0)
			useful_items++;
	endtask

	// Drain everything owed, then give an ignored item time to pass through.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.expected_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] seg, input logic [15:0] offs,
			input logic [4:0] lines);
		int first;
		int slot;
		logic [1:0] idx;
		logic [15:0] val;
		first = $urandom_range(0, 2);
		for (int j = 0; j < 4; j++) begin
			slot = (j < 3) ? (first + j) % 3 : 3;
			case (slot)
				0: begin
					idx = CFG_BASE_SEGMENT;
					val = seg;
				end
				1: begin
					idx = CFG_BASE_OFFSET;
					val = offs;
				end
				2: begin
					idx = CFG_ADDRESS_LINES;
					val = {11'd0, lines};
				end
				default: begin
					idx = CFG_UNUSED;
					val = 16'($urandom);
				end
			endcase
			if (slot == 3 && $urandom_range(0, 2) != 0)
				break;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
			tracker.write_reg(idx, val);
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFF - 16'($urandom_range(0, 40));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_config();
		logic [4:0] lines;
		case ($urandom_range(0, 7))
			0: lines = 5'd0;
			1: lines = 5'd1;
			2: lines = 5'd16;
			3: lines = 5'($urandom_range(17, 31));
			default: lines = 5'($urandom_range(2, 15));
		endcase
		settle();
		set_config(pick_word(), pick_word(), lines);
	endtask

	// One test run answering each read command; mostly clean readback with some faults.
	task automatic run_test(input bit may_abandon);
		logic [7:0] rd;
		send_item(OP_START, 8'($urandom));
		while (tracker.phase != PH_IDLE) begin
			if (may_abandon && $urandom_range(0, 5) == 0)
				return;
			if ($urandom_range(0, 49) == 0) begin
				random_config();
				mid_test_changes++;
			end
			if ($urandom_range(0, 59) == 0) begin
				send_item(OP_START, 8'($urandom));
				restarts++;
			end else begin
				if (tracker.phase == PH_DATA)
					rd = ($urandom_range(0, 4) != 0) ? tracker.pattern : 8'($urandom);
				else
					rd = ($urandom_range(0, 4) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
				send_item(OP_READ_DATA, rd);
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] rd;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_READ_DATA, 8'h5A);	// no test running: dropped
		settle();

		// no address lines, all-ones segment and offset, restart after the second read
		set_config(16'hFFFF, 16'hFFFF, 5'd0);
		send_item(OP_START, 8'h00);
		send_item(OP_READ_DATA, 8'h01);
		send_item(OP_READ_DATA, 8'hFD);
		send_item(OP_START, 8'hFF);
		restarts++;
		for (int b = 0; b < 8; b++) begin
			rd = 8'd1 << b;
			if (b == 1)
				rd = 8'h00;
			if (b == 4)
				rd = ~rd;
			if (b == 7)
				rd = 8'hFF;
			send_item(OP_READ_DATA, rd);
		end
		settle();

		// single line; offset wraps past 0xFFFF on the line location
		set_config(16'h0000, 16'hFFFF, 5'd1);
		send_item(OP_START, 8'h00);
		for (int b = 0; b < 8; b++)
			send_item(OP_READ_DATA, 8'd1 << b);
		send_item(OP_READ_DATA, 8'h80);

		while (useful_items < TOTAL_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				random_config();
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 4))
						send_item(($urandom_range(0, 9) == 0) ? OP_START : OP_READ_DATA,
							8'($urandom));
				end
				1: run_test(1'b1);
				default: run_test(1'b0);
			endcase
		end

		draining = 1'b1;
		settle();
		repeat (16) @(posedge clk);
		$display("Run covered %0d input beats (%0d with results), %0d result beats, %0d %s",
			sent_items, useful_items, tracker.checked, cfg_writes, "register writes.");
		$display("%0d tests completed, %0d with faults flagged; %0d %s, %0d restarts.",
			tracker.tests_done, tracker.faulty_tests, mid_test_changes,
			"mid-test reconfigurations", restarts);
		if (tracker.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : receiver
		int hold_cnt;
		bit held;
		int mode;
		int mode_left;
		bus_beat_t got;
		hold_cnt = 0;
		held = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {kind, mem_segment, mem_offset, write_data, data_fault_mask,
					addr_fault_mask, last};
				tracker.check_result(got);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 64);
			end
			mode_left--;
			if (draining) begin
				out_ready <= 1'b1;
			end else if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (!held && tracker.checked >= 60 && in_valid) begin
				// long back-pressure while the sender keeps offering: queue fills up
				held = 1'b1;
				hold_cnt = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (mode_left % 3 == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no beat on any channel for %0d cycles", $time, idle);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mbts_pkg.sv
sv/mbts_front.sv
sv/mbts_queue.sv
sv/mbts_back.sv
sv/memory_bus_test_sequencer_unit.sv
sim/memory_bus_test_sequencer_unit_tb.sv
